FILE: hw/rtl/pmst_pkg.sv
// shared types and constants for the prim minimum spanning tree block
package pmst_pkg;

  localparam int MaxVertices = 16;
  localparam int WeightBits = 16;
  localparam logic [4:0] VertexCountReset = 5'd16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_PICK,
    ST_RELAX,
    ST_RELAX_LAST,
    ST_OUT_RD,
    ST_OUT_CHK,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic start;
    logic scan_init;
    logic v_zero;
    logic v_one;
    logic scan_rd;
    logic incl;
    logic relax_rd;
    logic out_rd;
    logic emit_edge;
    logic emit_total;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_item;
    logic last_v;
    logic v_end;
    logic found;
    logic reached;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/pmst_ctrl.sv
// controller state machine for the prim minimum spanning tree block
module pmst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  pmst_pkg::status_t status,
  output pmst_pkg::cmd_t    cmd,
  output logic              in_stall
);

  pmst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmst_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      pmst_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) state_next = pmst_pkg::ST_LOAD;
      end
      pmst_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        in_stall = 1'b0;
        if (status.last_item) state_next = pmst_pkg::ST_START;
      end
      pmst_pkg::ST_START: begin
        cmd.start = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = pmst_pkg::ST_SCAN;
      end
      pmst_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.last_v) state_next = pmst_pkg::ST_SCAN_LAST;
      end
      pmst_pkg::ST_SCAN_LAST: begin
        state_next = pmst_pkg::ST_PICK;
      end
      pmst_pkg::ST_PICK: begin
        if (status.found) begin
          cmd.incl = 1'b1;
          cmd.v_zero = 1'b1;
          state_next = pmst_pkg::ST_RELAX;
        end else begin
          cmd.v_one = 1'b1;
          state_next = pmst_pkg::ST_OUT_RD;
        end
      end
      pmst_pkg::ST_RELAX: begin
        cmd.relax_rd = 1'b1;
        if (status.last_v) state_next = pmst_pkg::ST_RELAX_LAST;
      end
      pmst_pkg::ST_RELAX_LAST: begin
        cmd.scan_init = 1'b1;
        state_next = pmst_pkg::ST_SCAN;
      end
      pmst_pkg::ST_OUT_RD: begin
        if (status.v_end) begin
          state_next = pmst_pkg::ST_FINAL;
        end else begin
          cmd.out_rd = 1'b1;
          state_next = pmst_pkg::ST_OUT_CHK;
        end
      end
      pmst_pkg::ST_OUT_CHK: begin
        if (!status.reached) begin
          state_next = pmst_pkg::ST_OUT_RD;
        end else if (status.out_free) begin
          cmd.emit_edge = 1'b1;
          state_next = pmst_pkg::ST_OUT_RD;
        end
      end
      pmst_pkg::ST_FINAL: begin
        if (status.out_free) begin
          cmd.emit_total = 1'b1;
          state_next = pmst_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_next = pmst_pkg::ST_CLEAR;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == pmst_pkg::ST_PICK && !status.found) |=> state == pmst_pkg::ST_OUT_RD)
    else $error("pick without a candidate did not move to output");

endmodule

FILE: hw/rtl/pmst_datapath.sv
// edge store, vertex state, scan and relax logic, and output register
module pmst_datapath #(
  parameter int MAX_VERTICES = pmst_pkg::MaxVertices,
  parameter int WEIGHT_BITS = pmst_pkg::WeightBits
) (
  input  logic              clk,
  input  logic              rst,
  input  pmst_pkg::cmd_t    cmd,
  output pmst_pkg::status_t status,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_data,
  input  logic              in_valid,
  input  logic [3:0]        end_a,
  input  logic [3:0]        end_b,
  input  logic [15:0]       weight,
  input  logic              has_edge,
  input  logic              last_edge,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [3:0]        tree_parent,
  output logic [3:0]        tree_child,
  output logic [15:0]       edge_weight,
  output logic              is_edge,
  output logic [19:0]       total_weight,
  output logic              last
);

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = 2 * VB;
  localparam int W = WEIGHT_BITS;

  typedef struct packed {
    logic         inc;
    logic         fin;
    logic [W-1:0] key;
    logic [VB-1:0] par;
  } vs_t;

  // vertex count and used count
  logic [4:0] vertex_count;
  logic [7:0] vc8, n8;
  logic [CW-1:0] n;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pmst_pkg::VertexCountReset;
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  always_comb begin
    vc8 = {3'b000, vertex_count};
    if (vc8 == 8'd0) n8 = 8'd1;
    else if (vc8 > 8'(MAX_VERTICES)) n8 = 8'(MAX_VERTICES);
    else n8 = vc8;
    n = n8[CW-1:0];
  end

  // vertex counter
  logic [CW-1:0] v;
  logic [VB-1:0] v_idx;
  assign v_idx = v[VB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_init || cmd.v_zero) begin
      v <= '0;
    end else if (cmd.v_one) begin
      v <= CW'(1);
    end else if (cmd.scan_rd || cmd.relax_rd || cmd.out_rd) begin
      v <= v + CW'(1);
    end
  end

  // edge load
  logic [31:0] a32, b32, n32, w32;
  logic [VB-1:0] av, bv, lo, hi;
  logic [W-1:0] w_in;
  logic ld_ok;
  logic [AW-1:0] ld_addr;

  always_comb begin
    a32 = 32'(end_a);
    b32 = 32'(end_b);
    n32 = 32'(n);
    w32 = 32'(weight);
    w_in = w32[W-1:0];
    av = a32[VB-1:0];
    bv = b32[VB-1:0];
    lo = (av < bv) ? av : bv;
    hi = (av < bv) ? bv : av;
    ld_addr = {lo, hi};
    ld_ok = in_valid && cmd.load && has_edge && (a32 < n32) && (b32 < n32) &&
            (end_a != end_b);
  end

  logic p_valid;
  logic [AW-1:0] p_addr;
  logic [W-1:0] p_w;
  logic lw_valid;
  logic [AW-1:0] lw_addr;
  logic [W:0] lw_data;
  logic [W:0] adj_rd, adj_cur, adj_wd;
  logic ld_we, adj_we, adj_re;
  logic [AW-1:0] adj_wa, adj_ra, clr_cnt;

  // relax address
  logic [VB-1:0] u_reg, r_lo, r_hi;
  assign r_lo = (u_reg < v_idx) ? u_reg : v_idx;
  assign r_hi = (u_reg < v_idx) ? v_idx : u_reg;

  assign adj_cur = (lw_valid && lw_addr == p_addr) ? lw_data : adj_rd;
  assign ld_we = p_valid && !(adj_cur[W] && adj_cur[W-1:0] <= p_w);
  assign adj_we = cmd.clr || ld_we;
  assign adj_wa = cmd.clr ? clr_cnt : p_addr;
  assign adj_wd = cmd.clr ? '0 : {1'b1, p_w};
  assign adj_re = ld_ok || cmd.relax_rd;
  assign adj_ra = cmd.relax_rd ? {r_lo, r_hi} : ld_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      lw_valid <= 1'b0;
      clr_cnt <= '0;
    end else begin
      p_valid <= ld_ok;
      lw_valid <= ld_we && !cmd.clr;
      if (cmd.clr) clr_cnt <= clr_cnt + AW'(1);
      else if (cmd.emit_total) clr_cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= ld_addr;
    p_w <= w_in;
    lw_addr <= p_addr;
    lw_data <= {1'b1, p_w};
  end

  logic [W:0] adj_mem [2**AW];

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    if (adj_re) adj_rd <= adj_mem[adj_ra];
  end

  // vertex state store
  vs_t vs_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vvalid;
  vs_t vs_rd, ventry, vs_wd, best;
  logic vvalid_q, vs_re, vs_we, relax_we;
  logic [VB-1:0] vs_wa, vq, best_idx;
  logic sc_q, rx_q, best_valid, cand;

  assign vs_re = cmd.scan_rd || cmd.relax_rd || cmd.out_rd;
  assign ventry = vvalid_q ? vs_rd : '0;
  assign cand = sc_q && !ventry.inc && ventry.fin &&
                (!best_valid || ventry.key < best.key);
  assign relax_we = rx_q && adj_rd[W] && !ventry.inc &&
                    (!ventry.fin || adj_rd[W-1:0] < ventry.key);

  always_comb begin
    vs_we = 1'b1;
    vs_wa = vq;
    vs_wd.inc = 1'b0;
    vs_wd.fin = 1'b1;
    vs_wd.key = adj_rd[W-1:0];
    vs_wd.par = u_reg;
    if (cmd.start) begin
      vs_wa = '0;
      vs_wd.key = '0;
      vs_wd.par = '0;
    end else if (cmd.incl) begin
      vs_wa = best_idx;
      vs_wd.inc = 1'b1;
      vs_wd.key = best.key;
      vs_wd.par = best.par;
    end else if (!relax_we) begin
      vs_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[vs_wa] <= vs_wd;
    if (vs_re) vs_rd <= vs_mem[v_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0;
      vvalid_q <= 1'b0;
      sc_q <= 1'b0;
      rx_q <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      sc_q <= cmd.scan_rd;
      rx_q <= cmd.relax_rd;
      if (vs_re) vvalid_q <= vvalid[v_idx];
      if (cmd.start) begin
        vvalid <= MAX_VERTICES'(1);
      end else if (vs_we) begin
        vvalid[vs_wa] <= 1'b1;
      end
      if (cmd.scan_init) best_valid <= 1'b0;
      else if (cand) best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vs_re) vq <= v_idx;
    if (cand) begin
      best <= ventry;
      best_idx <= vq;
    end
    if (cmd.incl) u_reg <= best_idx;
  end

  // output register and running total
  logic [19:0] run_total;
  logic [31:0] par32, vq32, key32;

  assign par32 = 32'(ventry.par);
  assign vq32 = 32'(vq);
  assign key32 = 32'(ventry.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_edge || cmd.emit_total) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      run_total <= '0;
    end else if (cmd.emit_edge) begin
      run_total <= run_total + key32[19:0];
    end
    if (cmd.emit_edge) begin
      tree_parent <= par32[3:0];
      tree_child <= vq32[3:0];
      edge_weight <= key32[15:0];
      is_edge <= 1'b1;
      total_weight <= '0;
      last <= 1'b0;
    end else if (cmd.emit_total) begin
      tree_parent <= '0;
      tree_child <= '0;
      edge_weight <= '0;
      is_edge <= 1'b0;
      total_weight <= run_total;
      last <= 1'b1;
    end
  end

  // status
  always_comb begin
    status.clr_done = &clr_cnt;
    status.last_item = in_valid && last_edge;
    status.last_v = (v == n - CW'(1));
    status.v_end = (v >= n);
    status.found = best_valid;
    status.reached = ventry.fin;
    status.out_free = !out_valid || !out_stall;
  end

  assert property (@(posedge clk) disable iff (rst)
    relax_we |-> !cmd.start && !cmd.incl)
    else $error("relax write collides with another vertex write");

endmodule

FILE: hw/rtl/prim_minimum_spanning_tree.sv
// top level of the prim minimum spanning tree block
// load: one edge item per cycle; the final edge is written in the cycle after it is taken
// prim pass: up to n+1 scan steps over the vertex store
// output: one read and one check state per vertex, waiting on output register stalls, then the total item
// reset and every final item start a clearing pass over every entry of the edge store;
// no item is taken during it
module prim_minimum_spanning_tree #(
  parameter int MAX_VERTICES = pmst_pkg::MaxVertices,
  parameter int WEIGHT_BITS = pmst_pkg::WeightBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  end_a,
  input  logic [3:0]  end_b,
  input  logic [15:0] weight,
  input  logic        has_edge,
  input  logic        last_edge,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  tree_parent,
  output logic [3:0]  tree_child,
  output logic [15:0] edge_weight,
  output logic        is_edge,
  output logic [19:0] total_weight,
  output logic        last
);

  pmst_pkg::cmd_t cmd;
  pmst_pkg::status_t status;

  pmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  pmst_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .end_a        (end_a),
    .end_b        (end_b),
    .weight       (weight),
    .has_edge     (has_edge),
    .last_edge    (last_edge),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .tree_parent  (tree_parent),
    .tree_child   (tree_child),
    .edge_weight  (edge_weight),
    .is_edge      (is_edge),
    .total_weight (total_weight),
    .last         (last)
  );

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_edge || cmd.emit_total) |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled item");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> cmd.load)
    else $error("item taken outside the load phase");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (!is_edge && edge_weight == 16'd0))
    else $error("final item carries edge data");

endmodule

FILE: dv/prim_minimum_spanning_tree_tb.sv
// self-checking testbench for the prim minimum spanning tree block
module prim_minimum_spanning_tree_tb;

  typedef struct packed {
    logic [3:0]  parent;
    logic [3:0]  child;
    logic [15:0] wt;
    logic        is_edge;
    logic [19:0] total;
    logic        last;
  } tree_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] end_a = '0;
  logic [3:0] end_b = '0;
  logic [15:0] weight = '0;
  logic has_edge = 1'b0;
  logic last_edge = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] tree_parent;
  logic [3:0] tree_child;
  logic [15:0] edge_weight;
  logic is_edge;
  logic [19:0] total_weight;
  logic last;

  prim_minimum_spanning_tree i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .end_a(end_a), .end_b(end_b),
    .weight(weight), .has_edge(has_edge), .last_edge(last_edge),
    .out_valid(out_valid), .out_stall(out_stall), .tree_parent(tree_parent),
    .tree_child(tree_child), .edge_weight(edge_weight), .is_edge(is_edge),
    .total_weight(total_weight), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic        adj_ok [pmst_pkg::MaxVertices][pmst_pkg::MaxVertices];
  logic [15:0] adj_wt [pmst_pkg::MaxVertices][pmst_pkg::MaxVertices];
  logic [4:0]  vcount = pmst_pkg::VertexCountReset;
  tree_item_t  tree_q[$];
  int errors = 0;
  int edges_sent = 0;
  int trees_seen = 0;
  int results_seen = 0;
  bit calm = 1'b0;
  int idle_cycles = 0;
  int stall_left = 0;

  function automatic int n_used();
    if (vcount == 0) return 1;
    if (vcount > pmst_pkg::MaxVertices) return pmst_pkg::MaxVertices;
    return vcount;
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < pmst_pkg::MaxVertices; i++)
      for (int j = 0; j < pmst_pkg::MaxVertices; j++) begin
        adj_ok[i][j] = 1'b0;
        adj_wt[i][j] = '0;
      end
  endfunction

  function automatic void store_edge(int a, int b, logic [15:0] w);
    int n;
    n = n_used();
    if (a >= n || b >= n || a == b) return;
    if (adj_ok[a][b] && adj_wt[a][b] <= w) return;
    adj_ok[a][b] = 1'b1; adj_ok[b][a] = 1'b1;
    adj_wt[a][b] = w; adj_wt[b][a] = w;
  endfunction

  function automatic void predict_tree();
    int n, u;
    logic [15:0] key [pmst_pkg::MaxVertices];
    logic fin [pmst_pkg::MaxVertices];
    logic inc [pmst_pkg::MaxVertices];
    int par [pmst_pkg::MaxVertices];
    logic [19:0] sum;
    tree_item_t r;
    n = n_used();
    sum = '0;
    for (int i = 0; i < pmst_pkg::MaxVertices; i++) begin
      key[i] = '0; fin[i] = 1'b0; inc[i] = 1'b0; par[i] = -1;
    end
    fin[0] = 1'b1;
    for (int s = 0; s < n; s++) begin
      u = n;
      for (int v = 0; v < n; v++)
        if (!inc[v] && fin[v] && (u == n || key[v] < key[u])) u = v;
      if (u == n) break;
      inc[u] = 1'b1;
      for (int v = 0; v < n; v++)
        if (adj_ok[u][v] && !inc[v] && (!fin[v] || adj_wt[u][v] < key[v])) begin
          key[v] = adj_wt[u][v]; fin[v] = 1'b1; par[v] = u;
        end
    end
    for (int v = 1; v < n; v++) begin
      if (par[v] < 0) continue;
      r = '{parent: 4'(par[v]), child: 4'(v), wt: key[v], is_edge: 1'b1, total: '0,
            last: 1'b0};
      sum = sum + 20'(key[v]);
      tree_q.push_back(r);
    end
    r = '{parent: '0, child: '0, wt: '0, is_edge: 1'b0, total: sum, last: 1'b1};
    tree_q.push_back(r);
    clear_graph();
  endfunction

  task automatic send_item(int a, int b, int w, bit he, bit le);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    end_a <= 4'(a); end_b <= 4'(b); weight <= 16'(w); has_edge <= he; last_edge <= le;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (he) begin
      store_edge(a, b, 16'(w));
      edges_sent++;
    end
    if (le) predict_tree();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tree_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_count(int c);
    in_valid <= 1'b0;
    cfg_we <= 1'b1; cfg_data <= 5'(c);
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = 5'(c);
  endtask

  // random graph: mostly in-range edges, some noise
  task automatic send_graph(int edges);
    int n;
    n = n_used();
    for (int k = 0; k < edges; k++) begin
      if ($urandom_range(0, 9) < 8)
        send_item($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40),
                  1'b1, 1'b0);
      else
        send_item($urandom_range(0, 15), $urandom_range(0, 15), $urandom,
                  $urandom_range(0, 1), 1'b0);
    end
    send_item($urandom_range(0, 15), $urandom_range(0, 15), $urandom,
              $urandom_range(0, 1), 1'b1);
  endtask

  task automatic test_directed();
    send_item(0, 1, 16'hFFFF, 1'b1, 1'b0);
    send_item(1, 0, 16'hFFFF, 1'b1, 1'b0);
    send_item(1, 15, 0, 1'b1, 1'b0);
    send_item(15, 14, 7, 1'b1, 1'b0);
    send_item(14, 15, 3, 1'b1, 1'b0);
    send_item(14, 15, 3, 1'b1, 1'b0);
    send_item(5, 5, 1, 1'b1, 1'b0);
    send_item(2, 3, 9, 1'b0, 1'b0);
    send_item(2, 0, 16'h8000, 1'b1, 1'b0);
    send_item(3, 0, 16'h8000, 1'b1, 1'b1);
    wait_drained();
    send_item(0, 0, 0, 1'b0, 1'b1);
    wait_drained();
    set_count(3);
    send_item(0, 5, 1, 1'b1, 1'b0);
    send_item(0, 1, 4, 1'b1, 1'b0);
    send_item(2, 1, 4, 1'b1, 1'b1);
    wait_drained();
    set_count(0);
    send_item(0, 1, 2, 1'b1, 1'b1);
    wait_drained();
    set_count(31);
    for (int v = 1; v < 16; v++) send_item(v - 1, v, 16'hFFFF, 1'b1, 1'b0);
    send_item(0, 0, 0, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int counts [6] = '{16, 2, 1, 9, 5, 17};
    for (int p = 0; p < 6; p++) begin
      set_count(counts[p]);
      for (int g = 0; g < 4; g++) send_graph($urandom_range(3, 14));
      wait_drained();
    end
    set_count(16);
    calm = 1'b1;
    for (int g = 0; g < 3; g++) send_graph($urandom_range(10, 20));
  endtask

  // random output stall bursts, none started once calm is set
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    tree_item_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (tree_q.size() == 0) begin
        $error("unexpected item parent=%0d child=%0d", tree_parent, tree_child);
        errors++;
      end else begin
        e = tree_q.pop_front();
        if (tree_parent !== e.parent) begin
          $error("tree_parent exp %0d got %0d", e.parent, tree_parent); errors++;
        end
        if (tree_child !== e.child) begin
          $error("tree_child exp %0d got %0d", e.child, tree_child); errors++;
        end
        if (edge_weight !== e.wt) begin
          $error("edge_weight exp %0d got %0d", e.wt, edge_weight); errors++;
        end
        if (is_edge !== e.is_edge) begin
          $error("is_edge exp %0d got %0d", e.is_edge, is_edge); errors++;
        end
        if (total_weight !== e.total) begin
          $error("total_weight exp %0d got %0d", e.total, total_weight); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
        if (e.last) trees_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("prim_minimum_spanning_tree verification failed");
      $finish;
    end
  end

  initial begin
    clear_graph();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    wait_drained();
    $display("covered %0d edge items, %0d trees, %0d result items", edges_sent,
             trees_seen, results_seen);
    if (errors == 0) begin
      $display("prim_minimum_spanning_tree verification clean");
    end else begin
      $display("prim_minimum_spanning_tree verification failed");
    end
    $finish;
  end

endmodule
